### rtl/vigenere_cipher_stream_assert.svh
// Assertion macros for the Vigenere cipher stream block.
`ifndef VIGENERE_CIPHER_STREAM_ASSERT_SVH
`define VIGENERE_CIPHER_STREAM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VCS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vigenere_cipher_stream: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VCS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vigenere_cipher_stream: next-cycle check failed");

`endif

### rtl/vcs_pkg.sv
// Shared types, alphabet tables and lookup functions for the Vigenere cipher stream.
`timescale 1ns / 1ps

package vcs_pkg;

	localparam int KEY_DEPTH_DEF = 64;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ENC  = 2'd1;
	localparam logic [1:0] OP_DEC  = 2'd2;

	localparam logic [7:0] DOLLAR     = 8'h24;
	localparam logic [7:0] HIGH_BASE  = 8'hC0;
	localparam logic [7:0] HIGH_COUNT = 8'd64;
	localparam logic [7:0] DIGIT_IDX  = 8'd95;
	localparam logic [7:0] UPPER_IDX  = 8'd105;
	localparam logic [7:0] LOWER_IDX  = 8'd131;
	localparam logic [8:0] ALPHA_SIZE = 9'd157;

	localparam int PUNCT_COUNT = 31;
	localparam logic [7:0] PUNCT [PUNCT_COUNT] = '{
		8'h20, 8'h2E, 8'h2C, 8'h5F, 8'h3D, 8'h2B, 8'h3F, 8'h3E,
		8'h3C, 8'h0A, 8'h3B, 8'h3A, 8'h2F, 8'h21, 8'h2D, 8'h2A,
		8'h40, 8'h23, 8'h5E, 8'h25, 8'h7C, 8'h60, 8'h7E, 8'h27,
		8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h26
	};

	typedef struct packed {
		logic       ok;
		logic [7:0] idx;
	} idx_res_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic       enc;
		logic       bad;
		logic [7:0] pi;
		logic [7:0] ki;
	} stage_t;

	function automatic idx_res_t idx_of(input logic [7:0] b);
		idx_res_t r;
		r.ok  = 1'b0;
		r.idx = '0;
		if (b >= HIGH_BASE) begin
			r.ok  = 1'b1;
			r.idx = b - HIGH_BASE;
		end else if (b >= 8'h30 && b <= 8'h39) begin
			r.ok  = 1'b1;
			r.idx = DIGIT_IDX + (b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h5A) begin
			r.ok  = 1'b1;
			r.idx = UPPER_IDX + (b - 8'h41);
		end else if (b >= 8'h61 && b <= 8'h7A) begin
			r.ok  = 1'b1;
			r.idx = LOWER_IDX + (b - 8'h61);
		end else begin
			for (int i = 0; i < PUNCT_COUNT; i++) begin
				if (b == PUNCT[i]) begin
					r.ok  = 1'b1;
					r.idx = HIGH_COUNT + 8'(i);
				end
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] sym_of(input logic [7:0] idx);
		logic [7:0] s;
		logic [7:0] off;
		off = idx - HIGH_COUNT;
		if (idx < HIGH_COUNT)
			s = HIGH_BASE + idx;
		else if (idx < DIGIT_IDX)
			s = PUNCT[off[4:0]];
		else if (idx < UPPER_IDX)
			s = 8'h30 + (idx - DIGIT_IDX);
		else if (idx < LOWER_IDX)
			s = 8'h41 + (idx - UPPER_IDX);
		else
			s = 8'h61 + (idx - LOWER_IDX);
		return s;
	endfunction

endpackage

### rtl/vcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### rtl/vcs_keyctl.sv
// Key position tracking, key store write steering and post-reset clearing sweep.
`timescale 1ns / 1ps

module vcs_keyctl #(
	parameter int KEY_DEPTH = vcs_pkg::KEY_DEPTH_DEF,
	parameter int AW        = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          load,
	input  logic [7:0]    data_byte,
	input  logic [5:0]    key_addr,
	input  logic          start_of_message,
	input  logic [6:0]    key_length,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [7:0]    ram_wdata,
	output logic [AW-1:0] ram_raddr,
	output logic          clr_busy
);

	import vcs_pkg::*;

	localparam int LW = $clog2(KEY_DEPTH + 1);
	localparam int CW = (LW > 7) ? LW : 7;
	localparam int XW = (LW > 6) ? LW : 6;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;
	logic [CW-1:0] len_in;
	logic [CW-1:0] len_eff;
	logic [AW-1:0] cur;
	logic [CW-1:0] nxt;
	logic          addr_ok;

	always_comb begin
		len_in = CW'(key_length);
		if (key_length == 7'd0)
			len_eff = CW'(1);
		else if (len_in > CW'(KEY_DEPTH))
			len_eff = CW'(KEY_DEPTH);
		else
			len_eff = len_in;

		cur = start_of_message ? '0 : pos_q;
		if (CW'(cur) >= len_eff)
			cur = '0;
		nxt = CW'(cur) + CW'(1);
		if (nxt >= len_eff)
			nxt = '0;
	end

	assign addr_ok   = XW'(key_addr) < XW'(KEY_DEPTH);
	assign ram_we    = clr_busy_q || (load && addr_ok);
	assign ram_waddr = clr_busy_q ? clr_addr_q : AW'(key_addr);
	assign ram_wdata = clr_busy_q ? 8'h00 : data_byte;
	assign ram_raddr = cur;
	assign clr_busy  = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else begin
			if (step)
				pos_q <= nxt[AW-1:0];
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(KEY_DEPTH - 1))
					clr_busy_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/vcs_core.sv
// Symbol index lookup stage and modular add stage with the result register.
`timescale 1ns / 1ps

module vcs_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_s1,
	input  vcs_pkg::item_t item_s1,
	input  logic [7:0]    key_s1,
	input  logic          out_stall,
	output logic          s2_ready,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic          substituted
);

	import vcs_pkg::*;

	logic       v_s2;
	stage_t     st_s2;
	stage_t     st_d;
	idx_res_t   kres;
	idx_res_t   dres;
	logic       en_out;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       subst_q;
	logic [8:0] sum;
	logic [8:0] red;

	assign en_out   = !out_valid_q || !out_stall;
	assign s2_ready = !v_s2 || en_out;

	always_comb begin
		kres      = idx_of(key_s1);
		dres      = idx_of(item_s1.data);
		st_d.enc  = (item_s1.op == OP_ENC);
		st_d.bad  = !kres.ok || !dres.ok ||
			(item_s1.op == OP_DEC && item_s1.data == DOLLAR);
		st_d.pi   = dres.idx;
		st_d.ki   = kres.idx;
	end

	always_comb begin
		if (st_s2.enc)
			sum = {1'b0, st_s2.pi} + {1'b0, st_s2.ki};
		else
			sum = {1'b0, st_s2.pi} + ALPHA_SIZE - {1'b0, st_s2.ki};
		red = (sum >= ALPHA_SIZE) ? sum - ALPHA_SIZE : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready)
				v_s2 <= v_s1;
			if (en_out)
				out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready)
			st_s2 <= st_d;
		if (en_out) begin
			out_byte_q <= st_s2.bad ? DOLLAR : sym_of(red[7:0]);
			subst_q    <= st_s2.bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign substituted = subst_q;

endmodule

### rtl/vigenere_cipher_stream.sv
// Top level of the Vigenere cipher stream: handshakes, input stage and key store.
// Takes one byte per clock cycle when the output side is not stalled and no clearing sweep
// runs; each accepted byte goes through the input stage (key store read), the index lookup
// stage and the modular add into the output register. Key loads and opcode 3 give no result.
// After reset the key store is cleared by a sweep over all KEY_DEPTH entries, one entry
// per cycle through the single RAM write port, during which in_stall is high;
// key_length writes are taken at any time but should only be made while idle.
`timescale 1ns / 1ps

`include "vigenere_cipher_stream_assert.svh"

module vigenere_cipher_stream #(
	parameter int KEY_DEPTH = vcs_pkg::KEY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	input  logic [5:0] key_addr,
	input  logic       start_of_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       substituted,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] key_length
);

	import vcs_pkg::*;

	localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	logic [6:0]    key_length_q;
	logic          accept;
	logic          is_data;
	logic          en_s1;
	logic          s2_ready;
	logic          v_s1;
	item_t         item_s1;
	logic [7:0]    key_s1;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic          clr_busy;

	assign cfg_ready = 1'b1;
	assign is_data   = (opcode == OP_ENC) || (opcode == OP_DEC);
	assign en_s1     = !v_s1 || s2_ready;
	assign in_stall  = clr_busy || !en_s1;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= 7'd1;
			v_s1         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				key_length_q <= key_length;
			if (en_s1)
				v_s1 <= accept && is_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1.op   <= opcode;
			item_s1.data <= data_byte;
		end
	end

	vcs_keyctl #(
		.KEY_DEPTH (KEY_DEPTH),
		.AW        (AW)
	) u_keyctl (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (accept && is_data),
		.load             (accept && opcode == OP_LOAD),
		.data_byte        (data_byte),
		.key_addr         (key_addr),
		.start_of_message (start_of_message),
		.key_length       (key_length_q),
		.ram_we           (ram_we),
		.ram_waddr        (ram_waddr),
		.ram_wdata        (ram_wdata),
		.ram_raddr        (ram_raddr),
		.clr_busy         (clr_busy)
	);

	vcs_ram #(
		.WIDTH (8),
		.DEPTH (KEY_DEPTH),
		.AW    (AW)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (en_s1),
		.raddr (ram_raddr),
		.rdata (key_s1)
	);

	vcs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s1        (v_s1),
		.item_s1     (item_s1),
		.key_s1      (key_s1),
		.out_stall   (out_stall),
		.s2_ready    (s2_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.substituted (substituted)
	);

	`VCS_ASSERT_IMP(a_no_beat_in_sweep, clr_busy, !accept)
	`VCS_ASSERT_IMP(a_subst_dollar, out_valid && substituted, out_byte == DOLLAR)
	`VCS_ASSERT_IMP(a_plain_not_dollar, out_valid && !substituted, out_byte != DOLLAR)
	`VCS_ASSERT_NXT(a_s1_from_data, accept && !is_data, !v_s1)

endmodule
